@@ hw/rtl/qapd_pkg.sv @@
// ----------------------------------------------------------------------------
// qapd_pkg
// Shared types and constants of the quad attitude PD controller and mixer.
// ----------------------------------------------------------------------------
package qapd_pkg;

  localparam int NumMotors = 4;
  localparam int MomentW   = 60;
  localparam int SumW      = 61;
  localparam int ForceW    = 41;
  localparam int InnerW    = 27;
  localparam int RadW      = 48;
  localparam int RootW     = 24;
  localparam int RemW      = 27;
  localparam int NumerW    = 26;
  localparam int RecipW    = 28;
  localparam int ProdW     = 54;
  localparam int DivW      = 16;
  localparam int PulseW    = 11;
  localparam int RecipShift = 40;

  // Force thresholds of the thrust curve, millinewtons.
  localparam int ForceKnee = 1870;
  localparam int ForceTop  = 8530;

  // Radicand terms of the two curve pieces.
  localparam logic [InnerW-1:0] C1Slope  = InnerW'(37480);
  localparam logic [InnerW-1:0] C1Offset = InnerW'(11607241);
  localparam logic [InnerW-1:0] C2Slope  = InnerW'(631);
  localparam logic [InnerW-1:0] C2Offset = InnerW'(5690289);
  localparam logic [RadW-1:0]   RadScale = RadW'(1000000);

  // Numerator offsets, divisors and their reciprocals (floor of 2^40 / divisor).
  localparam logic [NumerW-1:0] C1Numer = NumerW'(37641000);
  localparam logic [NumerW-1:0] C2Numer = NumerW'(10017000);
  localparam logic [DivW-1:0]   C1Div   = DivW'(37480);
  localparam logic [DivW-1:0]   C2Div   = DivW'(6310);
  localparam logic [RecipW-1:0] C1Recip = RecipW'(29335955);
  localparam logic [RecipW-1:0] C2Recip = RecipW'(174249069);

  localparam logic [PulseW-1:0] PulseMin = PulseW'(1000);
  localparam logic [PulseW-1:0] PulseMax = PulseW'(1500);

  typedef enum logic [2:0] {
    CFG_KP_ROLL         = 3'd0,
    CFG_KP_PITCH        = 3'd1,
    CFG_KD_ROLL         = 3'd2,
    CFG_KD_PITCH        = 3'd3,
    CFG_ANGLE_ERR_LIMIT = 3'd4,
    CFG_HOVER_FORCE     = 3'd5,
    CFG_MOMENT_TO_FORCE = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PW_LOW,
    PW_SAT,
    PW_CURVE1,
    PW_CURVE2
  } pw_mode_e;

  typedef struct packed {
    logic signed [15:0] desired_roll;
    logic signed [15:0] desired_pitch;
    logic signed [15:0] measured_roll;
    logic signed [15:0] measured_pitch;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
  } qapd_in_t;

  typedef struct packed {
    logic [PulseW-1:0] motor1_pulse;
    logic [PulseW-1:0] motor2_pulse;
    logic [PulseW-1:0] motor3_pulse;
    logic [PulseW-1:0] motor4_pulse;
  } qapd_out_t;

  typedef struct packed {
    logic [15:0] kp_roll;
    logic [15:0] kp_pitch;
    logic [15:0] kd_roll;
    logic [15:0] kd_pitch;
    logic [14:0] angle_error_limit;
    logic [15:0] hover_force;
    logic [15:0] moment_to_force;
  } qapd_cfg_t;

  typedef struct packed {
    pw_mode_e        mode;
    logic [RadW-1:0] rad;
  } rad_lane_t;

  typedef struct packed {
    pw_mode_e         mode;
    logic [RootW-1:0] root;
    logic             rem_nz;
  } root_lane_t;

  typedef struct packed {
    pw_mode_e         mode;
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

endpackage

@@ hw/rtl/quad_attitude_pd_motor_mixer_top.sv @@
// ----------------------------------------------------------------------------
// quad_attitude_pd_motor_mixer_top
// Roll and pitch PD attitude control, four-motor mixer and thrust curve.
// ----------------------------------------------------------------------------
// An accepted request reaches its result through four moment stages, five
// mixing stages, 24 square-root stages and five pulse stages.
// Throughput is one request per cycle; each stage holds its request when the
// output is stalled and empty stages keep filling.
// Reset clears all valid bits and loads the gain registers with their
// default values; no clearing pass is needed.
module quad_attitude_pd_motor_mixer_top import qapd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  qapd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output qapd_out_t out_data_o
);

  qapd_cfg_t cfg_d, cfg_q;

  logic                      mom_in_ready, mom_valid, mix_ready;
  logic signed [MomentW-1:0] mom_roll, mom_pitch;
  logic                      mix_valid, sq_ready;
  rad_lane_t  [NumMotors-1:0] rad_lanes;
  logic                      sq_valid, pul_ready;
  root_lane_t [NumMotors-1:0] root_lanes;

  // Register writes; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KP_ROLL:         cfg_d.kp_roll = cfg_wdata_i;
        CFG_KP_PITCH:        cfg_d.kp_pitch = cfg_wdata_i;
        CFG_KD_ROLL:         cfg_d.kd_roll = cfg_wdata_i;
        CFG_KD_PITCH:        cfg_d.kd_pitch = cfg_wdata_i;
        CFG_ANGLE_ERR_LIMIT: cfg_d.angle_error_limit = cfg_wdata_i[14:0];
        CFG_HOVER_FORCE:     cfg_d.hover_force = cfg_wdata_i;
        CFG_MOMENT_TO_FORCE: cfg_d.moment_to_force = cfg_wdata_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{kp_roll: 16'd23, kp_pitch: 16'd38, kd_roll: 16'd563,
                 kd_pitch: 16'd768, angle_error_limit: 15'd4500,
                 hover_force: 16'd14710, moment_to_force: 16'd398};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = !mom_in_ready;

  qapd_moment u_moment (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (mom_in_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (mom_valid),
    .out_ready_i (mix_ready),
    .roll_o      (mom_roll),
    .pitch_o     (mom_pitch)
  );

  qapd_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (mom_valid),
    .in_ready_o  (mix_ready),
    .roll_i      (mom_roll),
    .pitch_i     (mom_pitch),
    .out_valid_o (mix_valid),
    .out_ready_i (sq_ready),
    .lanes_o     (rad_lanes)
  );

  qapd_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_valid),
    .in_ready_o  (sq_ready),
    .lanes_i     (rad_lanes),
    .out_valid_o (sq_valid),
    .out_ready_i (pul_ready),
    .lanes_o     (root_lanes)
  );

  qapd_pulse u_pulse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (pul_ready),
    .lanes_i     (root_lanes),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // Every delivered pulse width lies in the motor range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.motor1_pulse >= PulseMin && out_data_o.motor1_pulse <= PulseMax &&
       out_data_o.motor2_pulse >= PulseMin && out_data_o.motor2_pulse <= PulseMax &&
       out_data_o.motor3_pulse >= PulseMin && out_data_o.motor3_pulse <= PulseMax &&
       out_data_o.motor4_pulse >= PulseMin && out_data_o.motor4_pulse <= PulseMax))
    else $error("pulse width out of range");

  // A configuration write lands in the register the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == CFG_HOVER_FORCE) |=>
      (cfg_q.hover_force == $past(cfg_wdata_i)))
    else $error("hover force write lost");
`endif

endmodule

@@ hw/rtl/qapd_moment.sv @@
// ----------------------------------------------------------------------------
// qapd_moment
// Clamped angle error and PD moments of roll and pitch, scaled to force.
// ----------------------------------------------------------------------------
module qapd_moment import qapd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qapd_cfg_t                 cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  qapd_in_t                  in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [MomentW-1:0] roll_o,
  output logic signed [MomentW-1:0] pitch_o
);

  localparam int Stages = 4;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   rdy;

  logic signed [16:0] err_r_d, err_p_d, err_r_q, err_p_q;
  logic signed [15:0] rate_r_q, rate_p_q;
  logic signed [33:0] pe_r_d, pe_p_d, pe_r_q, pe_p_q;
  logic signed [32:0] de_r_d, de_p_d, de_r_q, de_p_q;
  logic signed [50:0] pm_r_d, pm_p_d, pm_r_q, pm_p_q;
  logic signed [49:0] dm_r_d, dm_p_d, dm_r_q, dm_p_q;
  logic signed [MomentW-1:0] mom_r_d, mom_p_d, mom_r_q, mom_p_q;

  function automatic logic signed [16:0] clamp_err(logic signed [15:0] des,
                                                   logic signed [15:0] meas,
                                                   logic [14:0] lim);
    logic signed [16:0] diff;
    logic signed [16:0] hi;
    diff = $signed({des[15], des}) - $signed({meas[15], meas});
    hi   = $signed({2'b00, lim});
    if (diff > hi) begin
      return hi;
    end else if (diff < -hi) begin
      return -hi;
    end else begin
      return diff;
    end
  endfunction

  function automatic logic signed [MomentW-1:0] combine(logic signed [50:0] pm,
                                                        logic signed [49:0] dm);
    logic signed [MomentW-1:0] p;
    logic signed [MomentW-1:0] d;
    p = MomentW'(pm);
    d = MomentW'(dm);
    return (p <<< 8) - (d <<< 4) - (d <<< 3) - d;
  endfunction

  // A stage can take a request when it is empty or its successor moves.
  assign rdy[Stages] = out_ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Datapath of the four stages.
  assign err_r_d = clamp_err(in_data_i.desired_roll, in_data_i.measured_roll,
                             cfg_i.angle_error_limit);
  assign err_p_d = clamp_err(in_data_i.desired_pitch, in_data_i.measured_pitch,
                             cfg_i.angle_error_limit);
  assign pe_r_d  = $signed({1'b0, cfg_i.kp_roll}) * err_r_q;
  assign pe_p_d  = $signed({1'b0, cfg_i.kp_pitch}) * err_p_q;
  assign de_r_d  = $signed({1'b0, cfg_i.kd_roll}) * rate_r_q;
  assign de_p_d  = $signed({1'b0, cfg_i.kd_pitch}) * rate_p_q;
  assign pm_r_d  = pe_r_q * $signed({1'b0, cfg_i.moment_to_force});
  assign pm_p_d  = pe_p_q * $signed({1'b0, cfg_i.moment_to_force});
  assign dm_r_d  = de_r_q * $signed({1'b0, cfg_i.moment_to_force});
  assign dm_p_d  = de_p_q * $signed({1'b0, cfg_i.moment_to_force});
  assign mom_r_d = combine(pm_r_q, dm_r_q);
  assign mom_p_d = combine(pm_p_q, dm_p_q);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      err_r_q  <= err_r_d;
      err_p_q  <= err_p_d;
      rate_r_q <= in_data_i.roll_rate;
      rate_p_q <= in_data_i.pitch_rate;
    end
    if (rdy[1]) begin
      pe_r_q <= pe_r_d;
      pe_p_q <= pe_p_d;
      de_r_q <= de_r_d;
      de_p_q <= de_p_d;
    end
    if (rdy[2]) begin
      pm_r_q <= pm_r_d;
      pm_p_q <= pm_p_d;
      dm_r_q <= dm_r_d;
      dm_p_q <= dm_p_d;
    end
    if (rdy[3]) begin
      mom_r_q <= mom_r_d;
      mom_p_q <= mom_p_d;
    end
  end

  assign roll_o  = mom_r_q;
  assign pitch_o = mom_p_q;

`ifndef ASSERT_OFF
  // The clamped roll error never leaves the configured band.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (err_r_q <= $signed({2'b00, cfg_i.angle_error_limit}) &&
                err_r_q >= -$signed({2'b00, cfg_i.angle_error_limit})))
    else $error("roll error outside clamp band");
`endif

endmodule

@@ hw/rtl/qapd_mix.sv @@
// ----------------------------------------------------------------------------
// qapd_mix
// Motor force mixing, rounding, curve selection and square-root radicands.
// ----------------------------------------------------------------------------
module qapd_mix import qapd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qapd_cfg_t                 cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [MomentW-1:0] roll_i,
  input  logic signed [MomentW-1:0] pitch_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rad_lane_t [NumMotors-1:0] lanes_o
);

  localparam int Stages = 5;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   rdy;

  logic signed [SumW-1:0]   sum_d   [NumMotors];
  logic signed [SumW-1:0]   sum_q   [NumMotors];
  logic signed [ForceW-1:0] force_d [NumMotors];
  logic signed [ForceW-1:0] force_q [NumMotors];
  pw_mode_e                 mode_d  [NumMotors];
  pw_mode_e                 mode3_q [NumMotors];
  pw_mode_e                 mode4_q [NumMotors];
  pw_mode_e                 mode5_q [NumMotors];
  logic [13:0]              fl_d    [NumMotors];
  logic [13:0]              fl_q    [NumMotors];
  logic [InnerW-1:0]        inner_d [NumMotors];
  logic [InnerW-1:0]        inner_q [NumMotors];
  logic [RadW-1:0]          rad_d   [NumMotors];
  logic [RadW-1:0]          rad_q   [NumMotors];

  assign rdy[Stages] = out_ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Mix signs: motor one roll minus pitch, two minus both, three plus both,
  // four pitch minus roll.
  always_comb begin
    sum_d[0] = SumW'(roll_i) - SumW'(pitch_i);
    sum_d[1] = -SumW'(roll_i) - SumW'(pitch_i);
    sum_d[2] = SumW'(roll_i) + SumW'(pitch_i);
    sum_d[3] = SumW'(pitch_i) - SumW'(roll_i);
  end

  // Force in 2^-23 mN, rounded half up to whole millinewtons.
  always_comb begin
    logic signed [63:0] t;
    for (int m = 0; m < NumMotors; m++) begin
      t = $signed({27'b0, cfg_i.hover_force, 21'b0}) + (64'(sum_q[m]) <<< 2)
          + 64'(sum_q[m]) + $signed({41'b0, 1'b1, 22'b0});
      force_d[m] = t[63:23];
    end
  end

  // Pick the curve piece; both ends of the range map to fixed pulses.
  always_comb begin
    for (int m = 0; m < NumMotors; m++) begin
      fl_d[m] = force_q[m][13:0];
      if (force_q[m] < 0) begin
        mode_d[m] = PW_LOW;
      end else if (force_q[m] < ForceW'(ForceKnee)) begin
        mode_d[m] = PW_CURVE1;
      end else if (force_q[m] < ForceW'(ForceTop)) begin
        mode_d[m] = PW_CURVE2;
      end else if (force_q[m] == ForceW'(ForceTop)) begin
        mode_d[m] = PW_LOW;
      end else begin
        mode_d[m] = PW_SAT;
      end
    end
  end

  // Radicand of the selected piece, then scaled by one million.
  always_comb begin
    for (int m = 0; m < NumMotors; m++) begin
      if (mode3_q[m] == PW_CURVE1) begin
        inner_d[m] = InnerW'(C1Slope * InnerW'(fl_q[m])) + C1Offset;
      end else begin
        inner_d[m] = C2Offset - InnerW'(C2Slope * InnerW'(fl_q[m]));
      end
      rad_d[m] = RadW'(inner_q[m]) * RadScale;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      if (rdy[0]) sum_q[m] <= sum_d[m];
      if (rdy[1]) force_q[m] <= force_d[m];
      if (rdy[2]) begin
        mode3_q[m] <= mode_d[m];
        fl_q[m]    <= fl_d[m];
      end
      if (rdy[3]) begin
        mode4_q[m] <= mode3_q[m];
        inner_q[m] <= inner_d[m];
      end
      if (rdy[4]) begin
        mode5_q[m] <= mode4_q[m];
        rad_q[m]   <= rad_d[m];
      end
    end
  end

  // The radicand stage reads the mode that came with its own request.
  for (genvar m = 0; m < NumMotors; m++) begin : g_out
    assign lanes_o[m].mode = mode5_q[m];
    assign lanes_o[m].rad  = rad_q[m];
  end

endmodule

@@ hw/rtl/qapd_isqrt.sv @@
// ----------------------------------------------------------------------------
// qapd_isqrt
// Four-lane pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qapd_isqrt import qapd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rad_lane_t [NumMotors-1:0]  lanes_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output root_lane_t [NumMotors-1:0] lanes_o
);

  localparam int Stages = RootW;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   rdy;
  sq_t               st_q [Stages][NumMotors];

  // One restoring step: bring down two radicand bits and try a one.
  function automatic sq_t sq_step(sq_t a);
    sq_t             b;
    logic [RemW-1:0] acc;
    logic [RemW-1:0] trial;
    acc    = {a.rem[RemW-3:0], a.rad[RadW-1:RadW-2]};
    trial  = {1'b0, a.root, 2'b01};
    b.mode = a.mode;
    b.rad  = {a.rad[RadW-3:0], 2'b00};
    if (acc >= trial) begin
      b.rem  = acc - trial;
      b.root = {a.root[RootW-2:0], 1'b1};
    end else begin
      b.rem  = acc;
      b.root = {a.root[RootW-2:0], 1'b0};
    end
    return b;
  endfunction

  assign rdy[Stages] = out_ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Iteration stages, one per root bit, for each motor lane.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumMotors; l++) begin
      if (rdy[0]) begin
        st_q[0][l] <= sq_step('{mode: lanes_i[l].mode, rad: lanes_i[l].rad,
                                rem: '0, root: '0});
      end
      for (int s = 1; s < Stages; s++) begin
        if (rdy[s]) st_q[s][l] <= sq_step(st_q[s-1][l]);
      end
    end
  end

  for (genvar l = 0; l < NumMotors; l++) begin : g_out
    assign lanes_o[l].mode   = st_q[Stages-1][l].mode;
    assign lanes_o[l].root   = st_q[Stages-1][l].root;
    assign lanes_o[l].rem_nz = (st_q[Stages-1][l].rem != '0);
  end

`ifndef ASSERT_OFF
  // A finished root leaves a remainder of at most twice the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Stages-1] |->
      (st_q[Stages-1][0].rem <= RemW'({st_q[Stages-1][0].root, 1'b0}) &&
       st_q[Stages-1][1].rem <= RemW'({st_q[Stages-1][1].root, 1'b0}) &&
       st_q[Stages-1][2].rem <= RemW'({st_q[Stages-1][2].root, 1'b0}) &&
       st_q[Stages-1][3].rem <= RemW'({st_q[Stages-1][3].root, 1'b0})))
    else $error("square root remainder out of range");
`endif

endmodule

@@ hw/rtl/qapd_pulse.sv @@
// ----------------------------------------------------------------------------
// qapd_pulse
// Curve numerator, division by constant through a reciprocal, pulse select.
// ----------------------------------------------------------------------------
module qapd_pulse import qapd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  root_lane_t [NumMotors-1:0] lanes_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output qapd_out_t                  out_data_o
);

  localparam int Stages = 5;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   rdy;

  pw_mode_e            mode_q [Stages-1][NumMotors];
  logic [NumerW-1:0]   numer_d [NumMotors];
  logic [NumerW-1:0]   numer_q [Stages-1][NumMotors];
  logic [ProdW-1:0]    prod_d  [NumMotors];
  logic [ProdW-1:0]    prod_q  [NumMotors];
  logic [PulseW-1:0]   q0_q    [2][NumMotors];
  logic [RemW-1:0]     back_d  [NumMotors];
  logic [RemW-1:0]     back_q  [NumMotors];
  logic [PulseW-1:0]   pulse_d [NumMotors];
  logic [PulseW-1:0]   pulse_q [NumMotors];

  function automatic logic [DivW-1:0] div_of(pw_mode_e mode);
    return (mode == PW_CURVE1) ? C1Div : C2Div;
  endfunction

  assign rdy[Stages] = out_ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    logic [NumerW-1:0] s;
    logic [RemW-1:0]   rem;
    for (int m = 0; m < NumMotors; m++) begin
      // The upper piece takes the square root rounded up.
      s = NumerW'(lanes_i[m].root) +
          NumerW'(lanes_i[m].mode == PW_CURVE2 && lanes_i[m].rem_nz);
      numer_d[m] = (lanes_i[m].mode == PW_CURVE1) ? C1Numer + s : C2Numer - s;
      // Quotient estimate from the reciprocal, at most one too low.
      prod_d[m] = ProdW'(numer_q[0][m]) *
                  ProdW'((mode_q[0][m] == PW_CURVE1) ? C1Recip : C2Recip);
      back_d[m] = RemW'(q0_q[0][m]) * RemW'(div_of(mode_q[2][m]));
      // One correction step, then the fixed pulses at both ends.
      rem = RemW'(numer_q[3][m]) - back_q[m];
      case (mode_q[3][m])
        PW_LOW:  pulse_d[m] = PulseMin;
        PW_SAT:  pulse_d[m] = PulseMax;
        default: pulse_d[m] = q0_q[1][m] +
                              PulseW'(rem >= RemW'(div_of(mode_q[3][m])));
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NumMotors; m++) begin
      if (rdy[0]) begin
        mode_q[0][m]  <= lanes_i[m].mode;
        numer_q[0][m] <= numer_d[m];
      end
      if (rdy[1]) begin
        mode_q[1][m]  <= mode_q[0][m];
        numer_q[1][m] <= numer_q[0][m];
        prod_q[m]     <= prod_d[m];
      end
      if (rdy[2]) begin
        mode_q[2][m]  <= mode_q[1][m];
        numer_q[2][m] <= numer_q[1][m];
        q0_q[0][m]    <= prod_q[m][RecipShift+PulseW-1:RecipShift];
      end
      if (rdy[3]) begin
        mode_q[3][m]  <= mode_q[2][m];
        numer_q[3][m] <= numer_q[2][m];
        q0_q[1][m]    <= q0_q[0][m];
        back_q[m]     <= back_d[m];
      end
      if (rdy[4]) pulse_q[m] <= pulse_d[m];
    end
  end

  assign out_data_o.motor1_pulse = pulse_q[0];
  assign out_data_o.motor2_pulse = pulse_q[1];
  assign out_data_o.motor3_pulse = pulse_q[2];
  assign out_data_o.motor4_pulse = pulse_q[3];

`ifndef ASSERT_OFF
  // The reciprocal estimate is never more than one below the quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && (mode_q[3][0] == PW_CURVE1 || mode_q[3][0] == PW_CURVE2)) |->
      (RemW'(numer_q[3][0]) - back_q[0] < {RemW'(div_of(mode_q[3][0])), 1'b0}))
    else $error("quotient estimate off by more than one");
`endif

endmodule
